// ===== rtl/slr_pkg.sv =====
// Shared types and constants for the streaming literal find-and-replace block.
// No dependencies; every other file imports this package.
package slr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } result_item_t;

endpackage

// ===== rtl/slr_if.sv =====
// Valid/ready stream interfaces for the text input and the rewritten output.
// Depends on slr_pkg for the payload types.
interface slr_in_if import slr_pkg::*; ();
  logic       valid;
  logic       ready;
  text_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slr_out_if import slr_pkg::*; ();
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stream_literal_replace_top.sv =====
// Each accepted byte's results pass via the burst register into the output register.
// Throughput: one text byte per cycle while each byte yields at most one output byte
// and the output is not stalled; a byte that yields more stalls the input while the
// burst register drains one byte per cycle into the output register, as the output takes them.
// Reset: synchronous; clears the window, the pending output and restores register defaults.
// Depends on slr_pkg, slr_if and slr_step.
module stream_literal_replace_top import slr_pkg::*; #(
  parameter int MAX_STRING_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  slr_in_if.sink                 text_in,
  slr_out_if.source              text_out
);

  localparam int CAP = (MAX_STRING_BYTES < 8) ? MAX_STRING_BYTES : 8;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] v;
    v = (raw == '0) ? LEN_W'(1) : raw;
    if (v > CAP_LEN) begin
      v = CAP_LEN;
    end
    return v;
  endfunction

  logic [CFG_DATA_W-1:0]      pattern_bytes;
  logic [LEN_W-1:0]           pattern_length;
  logic [CFG_DATA_W-1:0]      replacement_bytes;
  logic [LEN_W-1:0]           replacement_length;

  logic [CAP-1:0][BYTE_W-1:0] window;
  logic [LEN_W-1:0]           window_count;
  logic [CAP-1:0][BYTE_W-1:0] window_next;
  logic [LEN_W-1:0]           window_count_next;

  logic [CAP-1:0][BYTE_W-1:0] list;
  logic [LEN_W-1:0]           list_count;
  logic                       list_last;

  logic [CAP-1:0][BYTE_W-1:0] burst_bytes;
  logic [CAP-1:0][BYTE_W-1:0] burst_shift;
  logic [LEN_W-1:0]           burst_count;
  logic                       burst_last;

  logic                       out_valid;
  result_item_t               out_item;

  logic                       accept;
  logic                       pop;

  slr_step #(.CAP(CAP)) u_step (
    .window      (window),
    .count       (window_count),
    .plen        (eff_len(pattern_length)),
    .rlen        (eff_len(replacement_length)),
    .pattern     (pattern_bytes),
    .replacement (replacement_bytes),
    .item        (text_in.data),
    .window_next (window_next),
    .count_next  (window_count_next),
    .list        (list),
    .list_count  (list_count),
    .list_last   (list_last)
  );

  assign text_in.ready = (burst_count == '0) || ((burst_count == LEN_W'(1)) && pop);
  assign accept = text_in.valid && text_in.ready;
  assign pop = (burst_count != '0) && (!out_valid || text_out.ready);
  assign text_out.valid = out_valid;
  assign text_out.data = out_item;

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      burst_shift[i] = (i + 1 < CAP) ? burst_bytes[(i + 1 < CAP) ? i + 1 : i] : burst_bytes[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pattern_length <= LEN_W'(1);
      replacement_bytes <= '0;
      replacement_length <= LEN_W'(1);
      window_count <= '0;
      burst_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg_wdata;
          end
          REG_PATTERN_LENGTH: begin
            if (window_count == '0) begin
              pattern_length <= cfg_wdata[LEN_W-1:0];
            end
          end
          REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg_wdata;
          end
          REG_REPLACEMENT_LENGTH: begin
            replacement_length <= cfg_wdata[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        window_count <= window_count_next;
        burst_count <= list_count;
      end else if (pop) begin
        burst_count <= burst_count - LEN_W'(1);
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (text_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
      burst_bytes <= list;
      burst_last <= list_last;
    end else if (pop) begin
      burst_bytes <= burst_shift;
    end
    if (pop) begin
      out_item.out_byte <= burst_bytes[0];
      out_item.out_last <= burst_last && (burst_count == LEN_W'(1));
    end
  end

endmodule

// ===== rtl/slr_step.sv =====
// Next-state and result logic for one text byte: window insert, pattern compare,
// replacement or oldest-byte emission, and end-of-text flush. Depends on slr_pkg.
module slr_step import slr_pkg::*; #(
  parameter int CAP = 8
) (
  input  logic [CAP-1:0][BYTE_W-1:0] window,
  input  logic [LEN_W-1:0]           count,
  input  logic [LEN_W-1:0]           plen,
  input  logic [LEN_W-1:0]           rlen,
  input  logic [CFG_DATA_W-1:0]      pattern,
  input  logic [CFG_DATA_W-1:0]      replacement,
  input  text_item_t                 item,
  output logic [CAP-1:0][BYTE_W-1:0] window_next,
  output logic [LEN_W-1:0]           count_next,
  output logic [CAP-1:0][BYTE_W-1:0] list,
  output logic [LEN_W-1:0]           list_count,
  output logic                       list_last
);

  logic [LEN_W-1:0]           c0;
  logic [LEN_W-1:0]           c1;
  logic [CAP-1:0][BYTE_W-1:0] win_ins;
  logic [CAP-1:0][BYTE_W-1:0] shifted;
  logic [CAP-1:0][BYTE_W-1:0] rep_list;
  logic                       full;
  logic                       match;
  logic                       hit;

  always_comb begin
    c0 = (count >= plen) ? plen - LEN_W'(1) : count;
    c1 = c0 + LEN_W'(1);
    full = (c1 == plen);
    match = 1'b1;
    for (int i = 0; i < CAP; i++) begin
      win_ins[i] = (LEN_W'(i) == c0) ? item.text_byte : window[i];
    end
    for (int i = 0; i < CAP; i++) begin
      if (LEN_W'(i) < plen && win_ins[i] != pattern[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
      shifted[i] = (i + 1 < CAP) ? win_ins[(i + 1 < CAP) ? i + 1 : i] : win_ins[i];
      rep_list[i] = replacement[BYTE_W*i +: BYTE_W];
    end
    hit = full && match;

    window_next = win_ins;
    count_next = c1;
    list = win_ins;
    list_count = '0;
    list_last = item.end_of_text;
    priority if (hit) begin
      list = rep_list;
      list_count = rlen;
      count_next = '0;
    end else if (item.end_of_text) begin
      list_count = c1;
      count_next = '0;
    end else if (full) begin
      list_count = LEN_W'(1);
      window_next = shifted;
      count_next = plen - LEN_W'(1);
    end
  end

endmodule

// ===== tb/stream_literal_replace_top_tb.sv =====
// Self-checking testbench for stream_literal_replace_top: directed and random text streams,
// with a scoreboard class that predicts the rewritten byte stream and checks each output transfer.
// Depends on slr_pkg, slr_if and the RTL of stream_literal_replace_top.
module stream_literal_replace_top_tb;
  import slr_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 120;
  localparam int RUN_BYTES = 35;

  class replace_checker;
    logic [63:0] pat_bytes;
    logic [63:0] rep_bytes;
    logic [3:0] pat_len_raw;
    logic [3:0] rep_len_raw;
    logic [7:0] window [0:7];
    int unsigned held;
    result_item_t due[$];
    int errors;

    function new();
      pat_bytes = '0;
      rep_bytes = '0;
      pat_len_raw = 4'd1;
      rep_len_raw = 4'd1;
      held = 0;
      errors = 0;
    endfunction

    function int unsigned clamp_len(logic [3:0] raw);
      if (raw == 4'd0) return 1;
      if (raw > 4'd8) return 8;
      return raw;
    endfunction

    function int unsigned pattern_len();
      return clamp_len(pat_len_raw);
    endfunction

    function logic [7:0] pattern_byte(int unsigned k);
      return pat_bytes[8*k +: 8];
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_BYTES: pat_bytes = v;
        REG_PATTERN_LENGTH: if (held == 0) pat_len_raw = v[3:0];
        REG_REPLACEMENT_BYTES: rep_bytes = v;
        REG_REPLACEMENT_LENGTH: rep_len_raw = v[3:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b);
      result_item_t r;
      r.out_byte = b;
      r.out_last = 1'b0;
      due.push_back(r);
    endfunction

    function void take_text(text_item_t it);
      int unsigned plen;
      int unsigned rlen;
      int unsigned mark;
      bit hit;
      plen = clamp_len(pat_len_raw);
      rlen = clamp_len(rep_len_raw);
      mark = due.size();
      hit = 1'b1;
      if (held >= plen) held = plen - 1;
      window[held] = it.text_byte;
      held++;
      if (held == plen) begin
        for (int i = 0; i < plen; i++) begin
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < rlen; i++) push_byte(rep_bytes[8*i +: 8]);
          held = 0;
        end else begin
          push_byte(window[0]);
          for (int i = 1; i < held; i++) window[i-1] = window[i];
          held--;
        end
      end
      if (it.end_of_text) begin
        for (int i = 0; i < held; i++) push_byte(window[i]);
        held = 0;
        if (due.size() > mark) due[due.size()-1].out_last = 1'b1;
      end
    endfunction

    function void check_output(result_item_t got);
      result_item_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: output transfer with nothing expected: byte %h last %b",
                 $time, got.out_byte, got.out_last);
        return;
      end
      want = due.pop_front();
      if (want.out_byte !== got.out_byte || want.out_last !== got.out_last) begin
        errors++;
        $display("%0t: expected byte %h last %b, got byte %h last %b", $time,
                 want.out_byte, want.out_last, got.out_byte, got.out_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slr_in_if text_in();
  slr_out_if text_out();

  replace_checker chk;
  int tx_idle_pct;
  int rx_stall_pct;
  bit long_hold;
  bit hold_used;
  int hold_left;
  int quiet_cycles;

  stream_literal_replace_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .text_in(text_in),
    .text_out(text_out)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (text_in.valid && text_in.ready) chk.take_text(text_in.data);
    if (text_out.valid && text_out.ready) chk.check_output(text_out.data);
    if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      text_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold && !hold_used) begin
      text_out.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else begin
      text_out.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_text(logic [7:0] b, logic eot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      text_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_in.valid <= 1'b1;
    text_in.data.text_byte <= b;
    text_in.data.end_of_text <= eot;
    do @(posedge clk); while (!text_in.ready);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    chk.write_reg(idx, v);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    text_in.valid <= 1'b0;
    while (chk.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_len();
    case ($urandom_range(4))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    write_reg(REG_PATTERN_BYTES, v);
    v = {$urandom, $urandom};
    v[3:0] = pick_len();
    write_reg(REG_PATTERN_LENGTH, v);
    v = {$urandom, $urandom};
    if ($urandom_range(3) == 0) v = '1;
    write_reg(REG_REPLACEMENT_BYTES, v);
    v = {$urandom, $urandom};
    v[3:0] = pick_len();
    write_reg(REG_REPLACEMENT_LENGTH, v);
  endtask

  // Text is mostly built from whole pattern copies and broken prefixes so that the
  // window reaches its match and partial-match states; the rest is single pattern bytes and plain noise.
  task automatic send_run(int count);
    logic [7:0] text[$];
    int unsigned plen;
    int unsigned cut;
    int pick;
    plen = chk.pattern_len();
    while (text.size() < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        for (int j = 0; j < plen; j++) text.push_back(chk.pattern_byte(j));
      end else if (pick < 55 && plen > 1) begin
        cut = $urandom_range(plen - 1, 1);
        for (int j = 0; j < cut; j++) text.push_back(chk.pattern_byte(j));
        text.push_back(8'($urandom_range(255)));
      end else if (pick < 75) begin
        text.push_back(chk.pattern_byte($urandom_range(plen - 1)));
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    foreach (text[j]) begin
      send_text(text[j], (j == text.size() - 1) || ($urandom_range(24) == 0));
    end
  endtask

  initial begin
    chk = new();
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_PATTERN_BYTES;
    cfg_wdata = '0;
    text_in.valid = 1'b0;
    text_in.data = '0;
    text_out.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    long_hold = 1'b0;
    hold_used = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: a one-byte pattern of zero replaced by a single zero.
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
    settle();

    write_reg(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A563_6261);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_REPLACEMENT_BYTES, 64'hFFEE_DDCC_BBAA_9988);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
    send_text(8'h78, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h63, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    settle();

    // The window still holds two bytes, so the length write must not take effect.
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_FF00);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
    send_text(8'h63, 1'b1);
    settle();

    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_PATTERN_BYTES, 64'h1234_5678_9ABC_DEFF);
    write_reg(REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
    settle();

    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_PATTERN_BYTES, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_005A);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
    for (int k = 0; k < 8; k++) send_text((k % 2 == 0) ? 8'h00 : 8'hFF, k == 7);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; long_hold = 1'b1; end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 54; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      repeat (2) begin
        random_config();
        send_run(RUN_BYTES);
        settle();
      end
    end

    if (chk.errors == 0 && chk.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/slr_pkg.sv
rtl/slr_if.sv
rtl/slr_step.sv
rtl/stream_literal_replace_top.sv
tb/stream_literal_replace_top_tb.sv
